/* rtl/assert_macros.svh */
// Assertion macros shared by the nearest point search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define NPS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define NPS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/nps_pkg.sv */
// Shared types and constants of the nearest point search block.
package nps_pkg;

    localparam int INDEX_W     = 4;
    localparam int NPTS_W      = 5;
    localparam int CMD_W       = 2;
    localparam int DRAIN_STEPS = 3;
    localparam int DRAIN_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE    = 2'd0,
        CMD_NEAREST  = 2'd1,
        CMD_DIRECTED = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

    typedef struct packed {
        logic clear;
        logic feed;
        logic dir_mode;
    } scan_ctrl_t;

endpackage

/* rtl/nearest_point_search.sv */
// Top level of the nearest point search: point ring, scan control and result register.
// A write beat gives no result.
// For a query the ring of cells turns once after accept,
// one point a cycle into the distance pipeline, then come the drain and the output load.
// The next beat after a query is taken only once its result is loaded and the block is idle.
// rst_n clears control and num_points; the point table is undefined until written.
`include "assert_macros.svh"

module nearest_point_search #(
    parameter int MAX_POINTS = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_wdata,     // num_points
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // entry_index, pos_x, pos_y, pos_z, dir_x/y/z
    input  logic [((nps_pkg::INDEX_W + 6 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic [1:0]          s_axis_tuser,  // cmd
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // best_index, best_x/y/z, best_dist_sq
    output logic [((nps_pkg::INDEX_W + 5 * COORD_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                m_axis_tuser   // found
);

    localparam int C      = COORD_BITS;
    localparam int PW     = 3 * C;
    localparam int SW     = 2 * C + 2;
    localparam int XW     = nps_pkg::INDEX_W;
    localparam int OUT_DW = ((XW + 3 * C + SW + 7) / 8) * 8;
    localparam int IW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CMP_W  = (IW > nps_pkg::NPTS_W) ? IW : nps_pkg::NPTS_W;
    localparam int NSLOT  = 1 << XW;

    nps_pkg::state_t     state_reg;
    nps_pkg::state_t     state_next;
    logic [IW-1:0]       cnt_reg;
    logic [IW-1:0]       cnt_next;
    logic [nps_pkg::DRAIN_W-1:0] drn_reg;
    logic [nps_pkg::DRAIN_W-1:0] drn_next;
    logic [nps_pkg::NPTS_W-1:0]  npts_reg;
    logic [PW-1:0]       qpos_reg;
    logic [PW-1:0]       qdir_reg;
    logic                dmode_reg;

    logic                in_beat;
    logic                wr_beat;
    logic                q_beat;
    logic                scan_last;
    logic                drain_last;
    logic                shift_en;
    logic                out_load;
    nps_pkg::cmd_t       cmd;
    nps_pkg::scan_ctrl_t ctrl;

    logic [XW-1:0]       in_idx;
    logic [PW-1:0]       in_pos;
    logic [PW-1:0]       in_dir;
    logic [PW-1:0]       ring [MAX_POINTS];

    logic                best_found;
    logic [IW-1:0]       best_idx;
    logic [PW-1:0]       best_point;
    logic [SW-1:0]       best_dist;

    logic                mvalid_reg;
    logic [OUT_DW-1:0]   mdata_reg;
    logic                muser_reg;

    assign cmd     = nps_pkg::cmd_t'(s_axis_tuser);
    assign in_idx  = s_axis_tdata[XW-1:0];
    assign in_pos  = s_axis_tdata[XW +: PW];
    assign in_dir  = s_axis_tdata[XW + PW +: PW];
    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign wr_beat = in_beat && (cmd == nps_pkg::CMD_WRITE);
    assign q_beat  = in_beat && (cmd == nps_pkg::CMD_NEAREST || cmd == nps_pkg::CMD_DIRECTED);

    genvar i, j;
    generate
        for (i = 0; i < MAX_POINTS; i++)
        begin : g_cell
            localparam int NXT = (i + 1) % MAX_POINTS;
            logic [NSLOT-1:0] hit;

            for (j = 0; j < NSLOT; j++)
            begin : g_slot
                localparam int SLOT = j % MAX_POINTS;
                assign hit[j] = (SLOT == i) && (in_idx == XW'(j));
            end

            nps_cell #(
                .PW (PW)
            ) u_cell (
                .clk        (clk),
                .load_en    (wr_beat && (|hit)),
                .load_data  (in_pos),
                .shift_en   (shift_en),
                .shift_data (ring[NXT]),
                .data       (ring[i])
            );
        end
    endgenerate

    assign scan_last  = (cnt_reg == IW'(MAX_POINTS - 1));
    assign drain_last = (drn_reg == nps_pkg::DRAIN_W'(nps_pkg::DRAIN_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nps_pkg::ST_IDLE:
            begin
                if (q_beat)
                begin
                    state_next = nps_pkg::ST_SCAN;
                end
            end
            nps_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = nps_pkg::ST_DRAIN;
                end
            end
            nps_pkg::ST_DRAIN:
            begin
                if (drain_last)
                begin
                    state_next = nps_pkg::ST_DONE;
                end
            end
            nps_pkg::ST_DONE:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    state_next = nps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        shift_en      = 1'b0;
        out_load      = 1'b0;
        cnt_next      = '0;
        drn_next      = '0;
        case (state_reg)
            nps_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            nps_pkg::ST_SCAN:
            begin
                shift_en = 1'b1;
                cnt_next = scan_last ? '0 : cnt_reg + 1'b1;
            end
            nps_pkg::ST_DRAIN:
            begin
                drn_next = drain_last ? '0 : drn_reg + 1'b1;
            end
            nps_pkg::ST_DONE:
            begin
                out_load = !mvalid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign ctrl.clear    = q_beat;
    assign ctrl.feed     = shift_en && (CMP_W'(cnt_reg) < CMP_W'(npts_reg));
    assign ctrl.dir_mode = dmode_reg;

    nps_dist #(
        .C  (C),
        .IW (IW)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .idx        (cnt_reg),
        .point      (ring[0]),
        .qpos       (qpos_reg),
        .qdir       (qdir_reg),
        .best_found (best_found),
        .best_idx   (best_idx),
        .best_point (best_point),
        .best_dist  (best_dist)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nps_pkg::ST_IDLE;
            cnt_reg    <= '0;
            drn_reg    <= '0;
            npts_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drn_reg   <= drn_next;
            if (cfg_we)
            begin
                npts_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                mvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_beat)
        begin
            qpos_reg  <= in_pos;
            qdir_reg  <= in_dir;
            dmode_reg <= (cmd == nps_pkg::CMD_DIRECTED);
        end
        if (out_load)
        begin
            muser_reg <= best_found;
            mdata_reg <= best_found ? OUT_DW'({best_dist, best_point, XW'(best_idx)}) : '0;
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tuser  = muser_reg;

    `NPS_ASSERT(a_empty_is_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0), "no-hit beat carries nonzero data")
    `NPS_ASSERT(a_result_from_done, $rose(m_axis_tvalid) |-> $past(state_reg == nps_pkg::ST_DONE), "result raised outside done")
    `NPS_ASSERT_ALWAYS(a_ring_aligned, (state_reg == nps_pkg::ST_IDLE) |-> (cnt_reg == '0), "ring not aligned in idle")

endmodule

/* rtl/nps_cell.sv */
// One ring cell: holds a table point, loads on a write, passes it on when scanning.
module nps_cell #(
    parameter int PW = 48
) (
    input  logic          clk,
    input  logic          load_en,
    input  logic [PW-1:0] load_data,
    input  logic          shift_en,
    input  logic [PW-1:0] shift_data,
    output logic [PW-1:0] data
);

    logic [PW-1:0] point_reg;
    logic [PW-1:0] point_next;

    always_comb
    begin
        point_next = point_reg;
        if (load_en)
        begin
            point_next = load_data;
        end
        else if (shift_en)
        begin
            point_next = shift_data;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
    end

    assign data = point_reg;

endmodule

/* rtl/nps_dist.sv */
// Distance pipeline fed from the ring head: offsets, products, sums, best-so-far tracking.
module nps_dist #(
    parameter int C  = 16,
    parameter int IW = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  nps_pkg::scan_ctrl_t  ctrl,
    input  logic [IW-1:0]        idx,
    input  logic [3*C-1:0]       point,
    input  logic [3*C-1:0]       qpos,
    input  logic [3*C-1:0]       qdir,
    output logic                 best_found,
    output logic [IW-1:0]        best_idx,
    output logic [3*C-1:0]       best_point,
    output logic [2*C+1:0]       best_dist
);

    localparam int OW  = C + 1;
    localparam int PDW = OW + C;
    localparam int DOW = PDW + 2;
    localparam int SW  = 2 * C + 2;

    logic signed [OW-1:0]  off [3];
    logic signed [OW-1:0]  s1_off_reg [3];
    logic                  s1_valid_reg;
    logic [IW-1:0]         s1_idx_reg;
    logic [3*C-1:0]        s1_point_reg;

    logic [2*C-1:0]        s2_sq_reg [3];
    logic signed [PDW-1:0] s2_dp_reg [3];
    logic                  s2_valid_reg;
    logic [IW-1:0]         s2_idx_reg;
    logic [3*C-1:0]        s2_point_reg;

    logic [SW-1:0]         s3_dist_reg;
    logic                  s3_neg_reg;
    logic                  s3_valid_reg;
    logic [IW-1:0]         s3_idx_reg;
    logic [3*C-1:0]        s3_point_reg;

    logic                  found_reg;
    logic                  found_next;
    logic [IW-1:0]         bidx_reg;
    logic [3*C-1:0]        bpoint_reg;
    logic [SW-1:0]         bdist_reg;
    logic                  take;
    logic signed [DOW-1:0] dot_sum;

    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_axis
            logic signed [C-1:0]    p_c;
            logic signed [C-1:0]    q_c;
            logic signed [2*OW-1:0] sq_full;
            logic signed [PDW-1:0]  dp_full;
            logic signed [C-1:0]    d_c;

            assign p_c     = point[k*C +: C];
            assign q_c     = qpos[k*C +: C];
            assign d_c     = qdir[k*C +: C];
            assign off[k]  = OW'(p_c) - OW'(q_c);
            assign sq_full = s1_off_reg[k] * s1_off_reg[k];
            assign dp_full = s1_off_reg[k] * d_c;

            always_ff @(posedge clk)
            begin
                s1_off_reg[k] <= off[k];
                s2_sq_reg[k]  <= sq_full[2*C-1:0];
                s2_dp_reg[k]  <= dp_full;
            end
        end
    endgenerate

    assign dot_sum = DOW'(s2_dp_reg[0]) + DOW'(s2_dp_reg[1]) + DOW'(s2_dp_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.feed;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= idx;
        s1_point_reg <= point;
        s2_idx_reg   <= s1_idx_reg;
        s2_point_reg <= s1_point_reg;
        s3_idx_reg   <= s2_idx_reg;
        s3_point_reg <= s2_point_reg;
        s3_dist_reg  <= SW'(s2_sq_reg[0]) + SW'(s2_sq_reg[1]) + SW'(s2_sq_reg[2]);
        s3_neg_reg   <= dot_sum[DOW-1];
        if (take)
        begin
            bidx_reg   <= s3_idx_reg;
            bpoint_reg <= s3_point_reg;
            bdist_reg  <= s3_dist_reg;
        end
    end

    // strict less-than keeps the earlier slot on ties
    always_comb
    begin
        take = s3_valid_reg && !(ctrl.dir_mode && s3_neg_reg)
               && (!found_reg || (s3_dist_reg < bdist_reg));
        found_next = found_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
        end
    end

    assign best_found = found_reg;
    assign best_idx   = bidx_reg;
    assign best_point = bpoint_reg;
    assign best_dist  = bdist_reg;

endmodule
